FILE: sv/ipa_pkg.sv
`default_nettype none

package ipa_pkg;

  localparam int MAX_IDS_DEF = 256;
  localparam int CAP_RESET   = 256;

  localparam int CAP_W   = 9;
  localparam int ID_W    = 32;
  localparam int STAT_W  = 2;
  localparam int USED_W  = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_ILLEGAL = 2'd2;
  localparam logic [STAT_W-1:0] ST_ALREADY = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_BASE  = 2'd1;

endpackage

`default_nettype wire

FILE: sv/id_pool_allocator.sv
// id_pool_allocator: hands out and takes back identifiers from a pool of
// capacity slots, slot i carrying identifier id_base + i.
// request channel: in_valid / in_stall with cmd (0 allocate, 1 free) and
// free_id. result channel: out_valid / out_stall with alloc_id, status
// (0 ok, 1 empty, 2 illegal, 3 already free) and used_count.
// configuration: cfg_valid / cfg_ready with cfg_index (0 capacity,
// 1 id_base) and cfg_data; cfg_ready is always high. any write of a known
// register re-initializes the pool, so write only while the block is idle.
// a request passes the input and result registers; one request is taken
// every cycle unless stalled, as the stack top and the entry below it sit
// in registers and the free-list memory is read one entry ahead of use.
// when the result register is full and out_stall is high, the request in
// the input register waits and in_stall rises; nothing is dropped.
// rst is synchronous: the pool comes up with capacity 256 (limited to
// MAX_IDS), id_base 0, all slots free and index 0 handed out first. the
// free-list memory needs no clearing pass: entries never written since
// the last re-init read as their initial value through a low-water mark.
// slot busy bits sit in a memory read as the request enters; slots never
// handed out since the last re-init read as free through the same mark.
`default_nettype none

module id_pool_allocator #(
  parameter int MAX_IDS = ipa_pkg::MAX_IDS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          cmd,
  input  wire logic [ipa_pkg::ID_W-1:0]      free_id,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ipa_pkg::ID_W-1:0]           alloc_id,
  output logic [ipa_pkg::STAT_W-1:0]         status,
  output logic [ipa_pkg::USED_W-1:0]         used_count,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ipa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ipa_pkg::ID_W-1:0]      cfg_data
);
  import ipa_pkg::*;

  localparam int IDX_W = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int CNT_W = $clog2(MAX_IDS + 1);
  localparam int WID_W = CNT_W + 2;
  localparam int CAP_RST = (CAP_RESET > MAX_IDS) ? MAX_IDS : CAP_RESET;

  // configuration
  logic [CNT_W-1:0] cap;
  logic [ID_W-1:0]  id_base;
  logic             cfg_wr;
  logic             reinit;
  logic [CNT_W-1:0] cap_new;

  // input register
  logic             s1_valid;
  logic             s1_cmd;
  logic [ID_W-1:0]  s1_fid;

  // stack state
  logic [IDX_W-1:0] mem [MAX_IDS];
  logic [CNT_W-1:0] top;
  logic [CNT_W-1:0] min_top;
  logic [IDX_W-1:0] tos;
  logic [IDX_W-1:0] nxt_alt;
  logic             nxt_mem;
  logic [IDX_W-1:0] rd_data;
  logic             busy_mem [MAX_IDS];
  logic             busy_rd;

  // datapath
  logic             go;
  logic             pop;
  logic             push;
  logic [ID_W:0]    diff;
  logic             in_range;
  logic [IDX_W-1:0] fidx;
  logic [IDX_W-1:0] in_idx;
  logic             busy_we;
  logic [IDX_W-1:0] busy_waddr;
  logic             slot_busy;
  logic [IDX_W-1:0] nxt_val;
  logic [WID_W-1:0] rd_pos;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_written;
  logic [WID_W-1:0] init_pos;
  logic [IDX_W-1:0] init_val;
  logic [CNT_W-1:0] top_next;
  logic [STAT_W-1:0] status_next;
  logic [ID_W-1:0]  alloc_id_next;

  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid && cfg_ready;
  assign reinit = cfg_wr && (cfg_index == CFG_CAPACITY || cfg_index == CFG_ID_BASE);

  always_comb begin
    if (cfg_data[CAP_W-1:0] == '0) begin
      cap_new = CNT_W'(1);
    end else if (32'(cfg_data[CAP_W-1:0]) > 32'(MAX_IDS)) begin
      cap_new = CNT_W'(MAX_IDS);
    end else begin
      cap_new = CNT_W'(cfg_data[CAP_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap     <= CNT_W'(CAP_RST);
      id_base <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_CAPACITY: cap <= cap_new;
        CFG_ID_BASE:  id_base <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign go       = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd <= cmd;
      s1_fid <= free_id;
    end
  end

  // free range check without wrap
  assign diff     = {1'b0, s1_fid} - {1'b0, id_base};
  assign in_range = !diff[ID_W] && (diff[ID_W-1:0] < ID_W'(cap));
  assign fidx     = diff[IDX_W-1:0];

  // slots at or above the allocation high-water mark were never handed out
  assign in_idx     = free_id[IDX_W-1:0] - id_base[IDX_W-1:0];
  assign slot_busy  = busy_rd && (CNT_W'(fidx) < (cap - min_top));
  assign busy_we    = pop || push;
  assign busy_waddr = pop ? tos : fidx;

  always_ff @(posedge clk) begin
    if (busy_we) begin
      busy_mem[busy_waddr] <= pop;
    end
    if (in_valid && !in_stall) begin
      if (busy_we && busy_waddr == in_idx) begin
        busy_rd <= pop;
      end else begin
        busy_rd <= busy_mem[in_idx];
      end
    end
  end

  assign pop  = go && (s1_cmd == CMD_ALLOC) && (top != '0);
  assign push = go && (s1_cmd == CMD_FREE) && in_range && slot_busy && (top < cap);

  assign nxt_val = nxt_mem ? rd_data : nxt_alt;

  // entry three below the current top, prefetched on a pop
  assign rd_pos     = {2'b00, top} - WID_W'(3);
  assign rd_addr    = rd_pos[IDX_W-1:0];
  assign rd_written = ({2'b00, min_top} + WID_W'(3)) <= {2'b00, top};
  assign init_pos   = {2'b00, cap} + WID_W'(2) - {2'b00, top};
  assign init_val   = init_pos[IDX_W-1:0];

  always_comb begin
    top_next      = top;
    status_next   = ST_OK;
    alloc_id_next = '0;
    if (s1_cmd == CMD_ALLOC) begin
      if (top == '0) begin
        status_next = ST_EMPTY;
      end else begin
        top_next      = top - CNT_W'(1);
        alloc_id_next = id_base + ID_W'(tos);
      end
    end else begin
      if (!in_range) begin
        status_next = ST_ILLEGAL;
      end else if (!slot_busy || top >= cap) begin
        status_next = ST_ALREADY;
      end else begin
        top_next = top + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[top[IDX_W-1:0]] <= fidx;
    end
    if (pop) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || reinit) begin
      top     <= rst ? CNT_W'(CAP_RST) : (cfg_index == CFG_CAPACITY ? cap_new : cap);
      min_top <= rst ? CNT_W'(CAP_RST) : (cfg_index == CFG_CAPACITY ? cap_new : cap);
      tos     <= '0;
      nxt_alt <= IDX_W'(1);
      nxt_mem <= 1'b0;
    end else if (pop) begin
      top     <= top_next;
      if (top_next < min_top) begin
        min_top <= top_next;
      end
      tos     <= nxt_val;
      nxt_mem <= rd_written;
      nxt_alt <= init_val;
    end else if (push) begin
      top       <= top_next;
      tos       <= fidx;
      nxt_alt   <= tos;
      nxt_mem   <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      alloc_id   <= alloc_id_next;
      status     <= status_next;
      used_count <= USED_W'(cap - top_next);
    end
  end

endmodule

`default_nettype wire
